FILE: rtl/core/tscb_pkg.sv
// Types and constants shared by the three-state circuit breaker core.
// Holds the breaker mode and event codes, register indexes and state/result records.
// No dependencies.
package tscb_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned LIM_W   = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PROD_W  = CNT_W + PCT_W;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned IN_W    = 64;
  localparam int unsigned OUT_W   = 72;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOW       = 3'd0,
    OP_SUCCESS     = 3'd1,
    OP_FAILURE     = 3'd2,
    OP_TIMEOUT     = 3'd3,
    OP_RESET       = 3'd4,
    OP_FORCE_OPEN  = 3'd5,
    OP_FORCE_CLOSE = 3'd6
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FAIL_LIMIT    = 3'd0,
    REG_SUCCESS_LIMIT = 3'd1,
    REG_OPEN_HOLD     = 3'd2,
    REG_PROBE_LIMIT   = 3'd3,
    REG_WINDOW        = 3'd4,
    REG_SLOW_MS       = 3'd5,
    REG_SLOW_PCT      = 3'd6,
    REG_FAIL_PCT      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [LIM_W-1:0]  fail_count_limit;
    logic [LIM_W-1:0]  success_count_limit;
    logic [TIME_W-1:0] open_hold_ms;
    logic [LIM_W-1:0]  probe_limit;
    logic [TIME_W-1:0] window_ms;
    logic [TIME_W-1:0] slow_ms;
    logic [PCT_W-1:0]  slow_pct_limit;
    logic [PCT_W-1:0]  fail_pct_limit;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] changed_at;
    logic [LIM_W-1:0]  probe_count;
    logic [TIME_W-1:0] window_begin;
    logic [CNT_W-1:0]  window_fails;
    logic [CNT_W-1:0]  win_calls;
    logic [CNT_W-1:0]  fail_streak;
    logic [CNT_W-1:0]  success_streak;
    logic [CNT_W-1:0]  call_total;
    logic [CNT_W-1:0]  slow_total;
    logic [CNT_W-1:0]  slow_den;
    logic              slow_over;
    logic [CNT_W-1:0]  reject_count;
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] rejected_total;
    logic [CNT_W-1:0] fail_run;
    logic             state_changed;
    mode_t            breaker_state;
    logic             allowed;
  } result_t;

endpackage

FILE: rtl/core/tscb_step.sv
// Next-state and result logic for one breaker event.
// Purely combinational; the caller registers state and result. Uses tscb_pkg.
module tscb_step (
  input  tscb_pkg::state_t                 st_i,
  input  tscb_pkg::cfg_t                   cfg_i,
  input  logic [tscb_pkg::OP_W-1:0]        op_i,
  input  logic [tscb_pkg::TIME_W-1:0]      now_i,
  input  logic [tscb_pkg::TIME_W-1:0]      dur_i,
  output tscb_pkg::state_t                 st_o,
  output tscb_pkg::result_t                res_o
);
  import tscb_pkg::*;

  function automatic state_t enter_mode(state_t s, mode_t m, logic [TIME_W-1:0] now);
    state_t r;
    r = s;
    if (s.mode != m) begin
      r.mode       = m;
      r.changed_at = now;
      if (m == MODE_HALF) begin
        r.probe_count    = '0;
        r.success_streak = '0;
      end
      if (m == MODE_CLOSED) begin
        r.fail_streak    = '0;
        r.success_streak = '0;
        r.window_fails   = '0;
        r.win_calls      = '0;
        r.window_begin   = now;
      end
    end
    return r;
  endfunction

  function automatic state_t window_check(state_t s, cfg_t c, logic [TIME_W-1:0] now);
    state_t r;
    logic [TIME_W-1:0] age;
    r   = s;
    age = now - s.window_begin;
    if (c.window_ms != '0 && age >= c.window_ms) begin
      r.window_begin = now;
      r.window_fails = '0;
      r.win_calls    = '0;
    end
    return r;
  endfunction

  function automatic logic trip_test(state_t s, cfg_t c);
    logic [PROD_W-1:0] fail_lhs, fail_rhs, slow_lhs, slow_rhs;
    logic              trip;
    fail_lhs = PROD_W'(s.window_fails) * PROD_W'(PCT_SCALE);
    fail_rhs = PROD_W'(c.fail_pct_limit) * PROD_W'(s.win_calls);
    slow_lhs = PROD_W'(s.slow_total) * PROD_W'(PCT_SCALE);
    slow_rhs = PROD_W'(c.slow_pct_limit) * PROD_W'(s.slow_den);
    trip = 1'b0;
    if (s.fail_streak >= CNT_W'(c.fail_count_limit)) begin
      trip = 1'b1;
    end
    if (c.fail_pct_limit != '0 && s.win_calls != '0 && fail_lhs >= fail_rhs) begin
      trip = 1'b1;
    end
    if (c.slow_pct_limit != '0 && s.call_total != '0 && s.slow_over &&
        s.slow_den != '0 && slow_lhs >= slow_rhs) begin
      trip = 1'b1;
    end
    return trip;
  endfunction

  state_t            s;
  logic              allowed;
  logic [TIME_W-1:0] since_change;

  assign since_change = now_i - st_i.changed_at;

  always_comb begin
    s       = st_i;
    allowed = 1'b0;
    unique case (op_t'(op_i))
      OP_ALLOW: begin
        unique case (st_i.mode)
          MODE_CLOSED: allowed = 1'b1;
          MODE_OPEN: begin
            if (since_change >= cfg_i.open_hold_ms) begin
              s       = enter_mode(s, MODE_HALF, now_i);
              allowed = 1'b1;
            end else begin
              s.reject_count = s.reject_count + 1'b1;
            end
          end
          default: begin
            if (st_i.probe_count < cfg_i.probe_limit) begin
              s.probe_count = s.probe_count + 1'b1;
              allowed       = 1'b1;
            end else begin
              s.reject_count = s.reject_count + 1'b1;
            end
          end
        endcase
      end
      OP_SUCCESS: begin
        s.call_total     = s.call_total + 1'b1;
        s.fail_streak    = '0;
        s.success_streak = s.success_streak + 1'b1;
        s.win_calls      = s.win_calls + 1'b1;
        s = window_check(s, cfg_i, now_i);
        if (cfg_i.slow_pct_limit != '0 && dur_i > cfg_i.slow_ms) begin
          s.slow_total = s.slow_total + 1'b1;
          if (s.call_total != '0) begin
            s.slow_den  = s.call_total;
            s.slow_over = 1'b1;
          end
        end
        if (s.mode == MODE_HALF && s.success_streak >= CNT_W'(cfg_i.success_count_limit)) begin
          s = enter_mode(s, MODE_CLOSED, now_i);
        end
      end
      OP_FAILURE, OP_TIMEOUT: begin
        s.call_total     = s.call_total + 1'b1;
        s.fail_streak    = s.fail_streak + 1'b1;
        s.success_streak = '0;
        s.win_calls      = s.win_calls + 1'b1;
        s.window_fails   = s.window_fails + 1'b1;
        s = window_check(s, cfg_i, now_i);
        // open only counts; half-open reopens on any bad call
        if (s.mode == MODE_HALF || (s.mode == MODE_CLOSED && trip_test(s, cfg_i))) begin
          s = enter_mode(s, MODE_OPEN, now_i);
        end
      end
      OP_RESET: begin
        s.mode           = MODE_CLOSED;
        s.changed_at     = now_i;
        s.fail_streak    = '0;
        s.success_streak = '0;
        s.window_fails   = '0;
        s.win_calls      = '0;
        s.window_begin   = now_i;
        s.probe_count    = '0;
      end
      OP_FORCE_OPEN:  s = enter_mode(s, MODE_OPEN, now_i);
      OP_FORCE_CLOSE: s = enter_mode(s, MODE_CLOSED, now_i);
      default: ;
    endcase
  end

  assign st_o  = s;
  assign res_o = '{rejected_total: s.reject_count,
                   fail_run:       s.fail_streak,
                   state_changed:  (s.mode != st_i.mode),
                   breaker_state:  s.mode,
                   allowed:        allowed};

endmodule

FILE: rtl/core/three_state_circuit_breaker_core.sv
// Three-state circuit breaker core: handshakes, configuration and state registers.
// Instantiates tscb_step for the per-event update. Uses tscb_pkg.
//
// Usage:
//   Input channel in_*: one beat per event. in_tuser carries the operation code,
//   in_tdata carries now_ms and the call duration. Output channel out_*: one result beat
//   per event with allowed, breaker state, change flag, failure run and reject total.
//   Configuration: pulse cfg_we with cfg_index/cfg_wdata; write only while idle.
// Result: registered, presented in the cycle after its input beat is accepted.
// Throughput: one event per cycle when not stalled; breaker state and result register both
//   load in the accepting cycle, the update being a single pass through tscb_step.
// Stall: the result register holds while out_tready is low; in_tready then drops
//   until that beat is taken, and rises again in the same cycle it is taken.
// Reset (rst_n low, synchronous): breaker closed, all counters and times zero,
//   registers back to their defaults, no result pending.
module three_state_circuit_breaker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] now_ms, [63:32] call duration in ms
  input  logic [tscb_pkg::IN_W-1:0]       in_tdata,
  // [2:0] operation
  input  logic [tscb_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] allowed, [2:1] breaker_state, [3] state_changed, [35:4] fail_run,
  // [67:36] rejected_total, [71:68] zero
  output logic [tscb_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_we,
  input  logic [tscb_pkg::IDX_W-1:0]      cfg_index,
  input  logic [tscb_pkg::TIME_W-1:0]     cfg_wdata
);
  import tscb_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  state_t  st_r, st_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  tscb_step u_step (
    .st_i  (st_r),
    .cfg_i (cfg_r),
    .op_i  (in_tuser),
    .now_i (in_tdata[TIME_W-1:0]),
    .dur_i (in_tdata[2*TIME_W-1:TIME_W]),
    .st_o  (st_nxt),
    .res_o (res_nxt)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FAIL_LIMIT:    cfg_nxt.fail_count_limit    = cfg_wdata[LIM_W-1:0];
        REG_SUCCESS_LIMIT: cfg_nxt.success_count_limit = cfg_wdata[LIM_W-1:0];
        REG_OPEN_HOLD:     cfg_nxt.open_hold_ms        = cfg_wdata;
        REG_PROBE_LIMIT:   cfg_nxt.probe_limit         = cfg_wdata[LIM_W-1:0];
        REG_WINDOW:        cfg_nxt.window_ms           = cfg_wdata;
        REG_SLOW_MS:       cfg_nxt.slow_ms             = cfg_wdata;
        REG_SLOW_PCT:      cfg_nxt.slow_pct_limit      = cfg_wdata[PCT_W-1:0];
        REG_FAIL_PCT:      cfg_nxt.fail_pct_limit      = cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fail_count_limit    <= 16'd5;
      cfg_r.success_count_limit <= 16'd3;
      cfg_r.open_hold_ms        <= 32'd30000;
      cfg_r.probe_limit         <= 16'd3;
      cfg_r.window_ms           <= 32'd60000;
      cfg_r.slow_ms             <= 32'd5000;
      cfg_r.slow_pct_limit      <= 7'd50;
      cfg_r.fail_pct_limit      <= 7'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all-zero state is the closed breaker
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      // hold the result beat until taken
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - $bits(result_t))'(0), res_r};

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without a pending result");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted event produced no result");

  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (res_r.state_changed == (st_r.mode != $past(st_r.mode))))
    else $error("state_changed disagrees with mode update");

  a_result_mirrors_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (res_r.breaker_state == st_r.mode && res_r.fail_run == st_r.fail_streak &&
                 res_r.rejected_total == st_r.reject_count))
    else $error("result does not match stored state");

  a_idle_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(st_r))
    else $error("breaker state moved without an event");

endmodule
